// ----- hdl/vector_adpcm_frame_decoder_macros.svh -----
// ---------------------------------------------------------------------------
// vector adpcm frame decoder assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef VECTOR_ADPCM_FRAME_DECODER_MACROS_SVH
`define VECTOR_ADPCM_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define VADPCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VADPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vadpcm_pkg.sv -----
// ---------------------------------------------------------------------------
// vadpcm_pkg
// shared constants and types of the vector adpcm frame decoder
// ---------------------------------------------------------------------------
package vadpcm_pkg;

    localparam int CB_AW      = 7;
    localparam int SMP_W      = 16;
    localparam int ACC_W      = 32;
    localparam int FRAC_SHIFT = 11;

    localparam logic [5:0] SEED_END   = 6'd8;
    localparam logic [5:0] HDR0_POS   = 6'd8;
    localparam logic [5:0] HDR1_POS   = 6'd24;
    localparam logic [5:0] FRAME_LAST = 6'd39;

    localparam logic KIND_COEF = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED0,
        ST_SEED1,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic                    clr;
        logic                    iss;
        logic signed [ACC_W-1:0] init;
        logic signed [SMP_W-1:0] operand;
    } mac_cmd_t;

    typedef struct packed {
        logic                    idle;
        logic signed [SMP_W-1:0] sample;
    } mac_sts_t;

    typedef struct packed {
        logic                    valid;
        logic signed [SMP_W-1:0] sample;
        logic                    run_last;
        logic                    frame_end;
    } emit_t;

endpackage

// ----- hdl/vadpcm_cb_ram.sv -----
// ---------------------------------------------------------------------------
// vadpcm_cb_ram
// codebook store, one write port, one read port with registered data
// ---------------------------------------------------------------------------
module vadpcm_cb_ram (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic        [vadpcm_pkg::CB_AW-1:0]    waddr,
    input  logic signed [vadpcm_pkg::SMP_W-1:0]    wdata,
    input  logic        [vadpcm_pkg::CB_AW-1:0]    raddr,
    output logic signed [vadpcm_pkg::SMP_W-1:0]    rdata
);
    import vadpcm_pkg::*;

    logic signed [SMP_W-1:0] mem [2**CB_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/vadpcm_mac.sv -----
// ---------------------------------------------------------------------------
// vadpcm_mac
// shared multiply-accumulate: operand stage, product stage, 32-bit wrap
// accumulator and the shift/saturate back to a 16-bit sample
// ---------------------------------------------------------------------------
module vadpcm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vadpcm_pkg::mac_cmd_t                cmd,
    input  logic signed [vadpcm_pkg::SMP_W-1:0] coef,
    output vadpcm_pkg::mac_sts_t                sts
);
    import vadpcm_pkg::*;

    localparam int SH_W = ACC_W - FRAC_SHIFT;

    logic                    op_v_reg;
    logic signed [SMP_W-1:0] op_reg;
    logic                    prod_v_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic        [SH_W-1:0]  sh;

    assign prod_next = coef * op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            op_v_reg   <= cmd.iss;
            prod_v_reg <= op_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= cmd.operand;
        prod_reg <= prod_next;
        if (cmd.clr)
        begin
            acc_reg <= cmd.init;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // arithmetic shift, then clamp to 16 bits
    always_comb
    begin
        sh       = acc_reg[ACC_W-1:FRAC_SHIFT];
        sts.idle = !op_v_reg && !prod_v_reg;
        if ((&sh[SH_W-1:SMP_W-1]) || !(|sh[SH_W-1:SMP_W-1]))
        begin
            sts.sample = sh[SMP_W-1:0];
        end
        else if (sh[SH_W-1])
        begin
            sts.sample = {1'b1, {(SMP_W-1){1'b0}}};
        end
        else
        begin
            sts.sample = {1'b0, {(SMP_W-1){1'b1}}};
        end
    end

endmodule

// ----- hdl/vadpcm_ctrl.sv -----
// ---------------------------------------------------------------------------
// vadpcm_ctrl
// frame sequencer: byte position, seeds, header, residuals, history and the
// term schedule that drives the codebook read port and the shared mac
// ---------------------------------------------------------------------------
`include "vector_adpcm_frame_decoder_macros.svh"

module vadpcm_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic        [7:0]                   frame_byte,
    input  logic                                out_free,
    input  vadpcm_pkg::mac_sts_t                mac_sts,
    output logic        [vadpcm_pkg::CB_AW-1:0] cb_raddr,
    output vadpcm_pkg::mac_cmd_t                mac_cmd,
    output vadpcm_pkg::emit_t                   emit
);
    import vadpcm_pkg::*;

    ctrl_state_t             state_reg;
    ctrl_state_t             state_next;
    logic [5:0]              pos_reg;
    logic [7:0]              seed_reg [8];
    logic [2:0]              book_reg;
    logic [3:0]              shift_reg;
    logic signed [SMP_W-1:0] res_reg [8];
    logic [2:0]              gidx_reg;
    logic signed [SMP_W-1:0] hist_reg [2];
    logic [2:0]              tap_reg;
    logic                    sub_reg;
    logic [3:0]              k_reg;
    logic signed [SMP_W-1:0] s0_reg;
    logic                    last_byte_reg;
    logic                    group_end_reg;

    logic                    acc_byte;
    logic                    is_seed;
    logic                    is_hdr;
    logic                    seed_hi;
    logic signed [SMP_W-1:0] seed_s0;
    logic signed [SMP_W-1:0] seed_s1;
    logic [2:0]              tap_w;
    logic [2:0]              t_cur;
    logic [2:0]              j_idx;
    logic [2:0]              res_idx;
    logic                    term_last;
    logic signed [SMP_W-1:0] res_t;

    function automatic logic signed [SMP_W-1:0] nib_res(input logic [3:0] nib,
                                                        input logic [3:0] sh);
        logic signed [SMP_W-1:0] v;
        v = {nib, 12'd0};
        return v >>> sh;
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign acc_byte  = in_valid && in_ready && (kind == KIND_BYTE);
    assign is_seed   = (pos_reg < SEED_END);
    assign is_hdr    = (pos_reg == HDR0_POS) || (pos_reg == HDR1_POS);
    assign seed_hi   = (pos_reg == HDR1_POS);
    assign seed_s0   = {seed_reg[{seed_hi, 2'd0}], seed_reg[{seed_hi, 2'd1}]};
    assign seed_s1   = {seed_reg[{seed_hi, 2'd2}], seed_reg[{seed_hi, 2'd3}]};
    assign tap_w     = {gidx_reg[2:1], 1'b0};
    assign t_cur     = {tap_reg[2:1], sub_reg};
    assign j_idx     = k_reg[2:0] - 3'd2;
    assign res_idx   = t_cur - k_reg[2:0] + 3'd1;
    assign term_last = (k_reg == ({1'b0, t_cur} + 4'd1));
    assign res_t     = res_reg[t_cur];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        emit            = '0;
        mac_cmd.clr     = 1'b0;
        mac_cmd.iss     = 1'b0;
        mac_cmd.init    = {{(ACC_W-SMP_W-FRAC_SHIFT){res_t[SMP_W-1]}}, res_t,
                           {FRAC_SHIFT{1'b0}}};
        mac_cmd.operand = res_reg[res_idx];
        cb_raddr        = {book_reg, 1'b1, j_idx};
        if (k_reg == 4'd0)
        begin
            mac_cmd.operand = hist_reg[0];
            cb_raddr        = {book_reg, 1'b0, t_cur};
        end
        else if (k_reg == 4'd1)
        begin
            mac_cmd.operand = hist_reg[1];
            cb_raddr        = {book_reg, 1'b1, t_cur};
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_byte && !is_seed)
                begin
                    state_next = is_hdr ? ST_SEED0 : ST_ISSUE;
                end
            end
            ST_SEED0:
            begin
                if (out_free)
                begin
                    emit.valid  = 1'b1;
                    emit.sample = hist_reg[0];
                    state_next  = ST_SEED1;
                end
            end
            ST_SEED1:
            begin
                if (out_free)
                begin
                    emit.valid    = 1'b1;
                    emit.sample   = hist_reg[1];
                    emit.run_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                mac_cmd.iss = 1'b1;
                mac_cmd.clr = (k_reg == 4'd0);
                if (term_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_sts.idle)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid     = 1'b1;
                    emit.sample    = mac_sts.sample;
                    emit.run_last  = sub_reg;
                    emit.frame_end = sub_reg && last_byte_reg;
                    state_next     = sub_reg ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            book_reg  <= '0;
            shift_reg <= '0;
            gidx_reg  <= '0;
            k_reg     <= '0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            k_reg <= (state_reg == ST_ISSUE && !term_last) ? k_reg + 4'd1 : 4'd0;
            if (acc_byte)
            begin
                pos_reg <= (pos_reg == FRAME_LAST) ? 6'd0 : pos_reg + 6'd1;
                sub_reg <= 1'b0;
                if (is_hdr)
                begin
                    book_reg  <= frame_byte[6:4];
                    shift_reg <= frame_byte[3:0];
                    gidx_reg  <= '0;
                end
                else if (!is_seed)
                begin
                    gidx_reg <= (pos_reg[1:0] == 2'd3) ? 3'd0 : tap_w + 3'd2;
                end
            end
            else if (state_reg == ST_EMIT && out_free)
            begin
                sub_reg <= 1'b1;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (acc_byte)
        begin
            last_byte_reg <= (pos_reg == FRAME_LAST);
            group_end_reg <= (pos_reg[1:0] == 2'd3);
            tap_reg       <= tap_w;
            if (is_seed)
            begin
                seed_reg[pos_reg[2:0]] <= frame_byte;
            end
            else if (is_hdr)
            begin
                hist_reg[0] <= seed_s0;
                hist_reg[1] <= seed_s1;
            end
            else
            begin
                res_reg[tap_w]                 <= nib_res(frame_byte[7:4], shift_reg);
                res_reg[{tap_w[2:1], 1'b1}]    <= nib_res(frame_byte[3:0], shift_reg);
            end
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            if (!sub_reg)
            begin
                s0_reg <= mac_sts.sample;
            end
            else if (group_end_reg)
            begin
                hist_reg[0] <= s0_reg;
                hist_reg[1] <= mac_sts.sample;
            end
        end
    end

    `VADPCM_ASSERT_SAME(a_emit_room, emit.valid, out_free, "sample issued into a full output register")
    `VADPCM_ASSERT_NEXT(a_hdr_seed, acc_byte && is_hdr, state_reg == ST_SEED0, "header beat did not start seed output")
    `VADPCM_ASSERT_SAME(a_clr_first, mac_cmd.clr, mac_cmd.iss && (k_reg == 4'd0), "accumulator cleared off the first term")
    `VADPCM_ASSERT_SAME(a_clr_drained, mac_cmd.clr, mac_sts.idle, "accumulator cleared with terms in flight")

endmodule

// ----- hdl/vector_adpcm_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// vector_adpcm_frame_decoder
// order-2 vector adpcm decoder for 40-byte frames, two 32-sample subframes
// ---------------------------------------------------------------------------
// The block takes one beat per input: kind 0 writes one 16-bit coefficient
// into the 128-word codebook (load every word a frame will use before
// sending it), kind 1 delivers the next frame byte. Seed bytes 0..7 give no
// output; header bytes 8 and 24 give the two seed samples of their subframe;
// every other byte gives two predicted samples, run_last marking the second
// and frame_end the 64th sample of the frame. Decoding runs through the
// single shared multiply-accumulate: tap t needs t+2 codebook reads, issued
// one per cycle through the one read port of the codebook memory, followed
// by a drain of the memory, product and accumulate stages before the sample
// is handed to the output register. No new input beat is taken while a
// byte is decoded. The output register decouples the sides: a new input
// beat is taken while the last sample of the previous one still waits for
// out_ready.
// ---------------------------------------------------------------------------
module vector_adpcm_frame_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic        [6:0]                   coef_index,
    input  logic signed [vadpcm_pkg::SMP_W-1:0] coef_value,
    input  logic        [7:0]                   frame_byte,
    // output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [vadpcm_pkg::SMP_W-1:0] sample,
    output logic                                run_last,
    output logic                                frame_end
);
    import vadpcm_pkg::*;

    logic                    out_valid_reg;
    logic signed [SMP_W-1:0] sample_reg;
    logic                    run_last_reg;
    logic                    frame_end_reg;
    logic                    out_free;
    logic                    cb_we;
    logic [CB_AW-1:0]        cb_raddr;
    logic signed [SMP_W-1:0] cb_rdata;
    mac_cmd_t                mac_cmd;
    mac_sts_t                mac_sts;
    emit_t                   emit;

    // output register may load when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // codebook beats write straight into the memory
    assign cb_we = in_valid && in_ready && (kind == KIND_COEF);

    vadpcm_cb_ram u_cb_ram (
        .clk   (clk),
        .we    (cb_we),
        .waddr (coef_index),
        .wdata (coef_value),
        .raddr (cb_raddr),
        .rdata (cb_rdata)
    );

    vadpcm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .coef  (cb_rdata),
        .sts   (mac_sts)
    );

    vadpcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .frame_byte (frame_byte),
        .out_free   (out_free),
        .mac_sts    (mac_sts),
        .cb_raddr   (cb_raddr),
        .mac_cmd    (mac_cmd),
        .emit       (emit)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit.valid)
        begin
            sample_reg    <= emit.sample;
            run_last_reg  <= emit.run_last;
            frame_end_reg <= emit.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// vector_adpcm_frame_decoder testbench
// drives codebook writes and 40-byte frames through the valid/ready input,
// predicts every decoded sample with a cycle-free model of the decoder and
// checks each output beat in order, with random gaps and stalls on both sides
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import vadpcm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off, fills the block
    localparam int TAIL_CYCLES = 40;    // covers the worst residual byte plus output
    localparam int FRAME_LEN   = 40;

    // directed frame content: extreme seeds, then residual nibble patterns
    localparam logic [63:0] SEED_PAT  = 64'h8000_7FFF_FFFF_0001;
    localparam logic [63:0] RESID_PAT = 64'h807F_08F7_00FF_8877;
    localparam logic [31:0] EDGE_BYTES = 32'h807F_00FF;

    // one expected output beat
    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    run_last;
        logic                    frame_end;
    } pcm_beat_t;

    // -----------------------------------------------------------------------
    // sample predictor and in-order checker
    // -----------------------------------------------------------------------
    class pcm_scoreboard;
        logic signed [SMP_W-1:0] coef_mem [128];
        logic [7:0]              seed_mem [8];
        logic [5:0]              frame_pos;
        int                      book;
        int                      shift_amt;
        int                      tap_next;
        int                      resid [8];
        int                      hist [2];
        pcm_beat_t               expected_q [$];
        int                      errors;

        function new();
            frame_pos = '0;
            book      = 0;
            shift_amt = 0;
            tap_next  = 0;
            errors    = 0;
            foreach (coef_mem[i]) coef_mem[i] = '0;
            foreach (seed_mem[i]) seed_mem[i] = '0;
            foreach (resid[i]) resid[i] = 0;
            hist[0] = 0;
            hist[1] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int nibble_resid(logic [3:0] nib);
            int v;
            v = {{28{nib[3]}}, nib};
            v = v * 4096;
            return v >>> shift_amt;
        endfunction

        function int tap_coef(int half, int tap);
            return int'(coef_mem[book * 16 + half * 8 + tap]);
        endfunction

        // 32-bit wrapping mac, then >>> 11 and saturation to 16 bits
        function int predict(int tap);
            int acc;
            int s;
            int j;
            acc = resid[tap] * 2048;
            acc += tap_coef(0, tap) * hist[0];
            acc += tap_coef(1, tap) * hist[1];
            for (j = 0; j < tap; j++)
                acc += tap_coef(1, j) * resid[tap - 1 - j];
            s = acc >>> FRAC_SHIFT;
            if (s > 32767)
                s = 32767;
            else if (s < -32768)
                s = -32768;
            return s;
        endfunction

        function void push_pair(int s0, int s1, logic fend);
            pcm_beat_t e;
            e.sample    = s0[SMP_W-1:0];
            e.run_last  = 1'b0;
            e.frame_end = 1'b0;
            expected_q.push_back(e);
            e.sample    = s1[SMP_W-1:0];
            e.run_last  = 1'b1;
            e.frame_end = fend;
            expected_q.push_back(e);
        endfunction

        // called once per accepted input beat
        function void note_beat(logic k, logic [6:0] idx, logic signed [SMP_W-1:0] val,
                                logic [7:0] b);
            logic [5:0] p;
            int         base;
            int         run_pos;
            int         tap;
            int         s0;
            int         s1;
            if (k == KIND_COEF) begin
                coef_mem[idx] = val;
                return;
            end
            p = frame_pos;
            frame_pos = (p == FRAME_LAST) ? 6'd0 : p + 6'd1;
            if (p < SEED_END) begin
                seed_mem[p[2:0]] = b;
                return;
            end
            if (p == HDR0_POS || p == HDR1_POS) begin
                base      = (p == HDR0_POS) ? 0 : 4;
                book      = b[6:4];
                shift_amt = b[3:0];
                s0 = int'($signed({seed_mem[base], seed_mem[base + 1]}));
                s1 = int'($signed({seed_mem[base + 2], seed_mem[base + 3]}));
                hist[0]  = s0;
                hist[1]  = s1;
                tap_next = 0;
                push_pair(s0, s1, 1'b0);
                return;
            end
            run_pos = (p < HDR1_POS) ? p - HDR0_POS : p - HDR1_POS;
            tap = tap_next & 6;
            resid[tap]     = nibble_resid(b[7:4]);
            resid[tap + 1] = nibble_resid(b[3:0]);
            s0 = predict(tap);
            s1 = predict(tap + 1);
            if ((run_pos & 3) == 3) begin
                hist[0]  = s0;
                hist[1]  = s1;
                tap_next = 0;
            end else begin
                tap_next = (tap + 2) & 7;
            end
            push_pair(s0, s1, p == FRAME_LAST);
        endfunction

        // called once per accepted output beat
        function void check_beat(logic signed [SMP_W-1:0] smp, logic rl, logic fe);
            pcm_beat_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected output beat: sample %0d run_last %0b frame_end %0b",
                       smp, rl, fe);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (smp !== want.sample) begin
                $error("sample: expected %0d actual %0d", want.sample, smp);
                errors++;
            end
            if (rl !== want.run_last) begin
                $error("run_last: expected %0b actual %0b", want.run_last, rl);
                errors++;
            end
            if (fe !== want.frame_end) begin
                $error("frame_end: expected %0b actual %0b", want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // dut and its signals
    // -----------------------------------------------------------------------
    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    kind;
    logic [6:0]              coef_index;
    logic signed [SMP_W-1:0] coef_value;
    logic [7:0]              frame_byte;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] sample;
    logic                    run_last;
    logic                    frame_end;

    pcm_scoreboard sb;
    int            beats_sent;
    bit            no_idle;     // both sides run back to back while set
    bit            hold_req;    // asks the sink for one long hold-off

    vector_adpcm_frame_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .frame_byte (frame_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // -----------------------------------------------------------------------
    // input side: one beat, an optional gap in front, payload held until taken
    // -----------------------------------------------------------------------
    task automatic send_beat(input logic k, input logic [6:0] idx,
                             input logic signed [SMP_W-1:0] val, input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        coef_index <= idx;
        coef_value <= val;
        frame_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(k, idx, val, b);
        beats_sent++;
        @(negedge clk);
    endtask

    // unused payload fields carry random junk, the block must ignore it
    task automatic send_coef(input logic [6:0] idx, input logic signed [SMP_W-1:0] val);
        send_beat(KIND_COEF, idx, val, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(KIND_BYTE, 7'($urandom), 16'($urandom), b);
    endtask

    // sender stops until every predicted sample has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // mostly q11-sized taps, some full range, a few extremes
    function automatic logic signed [SMP_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 8191) - 4096);
        if (r < 95)
            return 16'($urandom);
        return r[0] ? 16'sh7FFF : 16'sh8000;
    endfunction

    // -----------------------------------------------------------------------
    // output side: random stalls, plus one long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin : sink
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!no_idle)
                    stall = pick_gap();
            end
        end
    end

    // output beats are sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(sample, run_last, frame_end);
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("** vector_adpcm_frame_decoder: FAILED **");
        $finish;
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        int         i;
        int         frame_no;
        logic [7:0] b;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_COEF;
        coef_index = '0;
        coef_value = '0;
        frame_byte = '0;
        out_ready  = 1'b0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        beats_sent = 0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full codebook before any header, so no unwritten word is ever read;
        // book 7 holds the extremes to force wrap and saturation
        for (i = 0; i < 128; i++)
        begin
            if (i >= 112)
                send_coef(7'(i), (i < 120) ? 16'sh7FFF : 16'sh8000);
            else
                send_coef(7'(i), rand_coef());
        end

        // directed frame: extreme seeds, header bit 7 set with book 7 and
        // no shift, then book 0 with the largest shift, nibbles -8/+7/0/-1,
        // and a codebook write in the middle of the frame
        for (i = 0; i < FRAME_LEN; i++)
        begin
            if (i < SEED_END)
                b = SEED_PAT[63 - 8 * i -: 8];
            else if (i == HDR0_POS)
                b = 8'hF0;
            else if (i == HDR1_POS)
                b = 8'h0F;
            else
                b = RESID_PAT[63 - 8 * (i % 8) -: 8];
            send_byte(b);
            if (i == 15)
                send_coef(7'd0, 16'sh8000);
        end

        // random frames with the odd codebook rewrite in between bytes
        frame_no = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            no_idle = (frame_no % 6 == 5);
            if (frame_no == 8)
                hold_req = 1'b1;
            if (frame_no == 16)
                wait_drained();
            for (i = 0; i < FRAME_LEN; i++)
            begin
                if ($urandom_range(0, 99) < 4)
                    send_coef(7'($urandom), rand_coef());
                if (i < SEED_END && $urandom_range(0, 9) == 0)
                    b = EDGE_BYTES[8 * $urandom_range(0, 3) +: 8];
                else
                    b = 8'($urandom);
                send_byte(b);
            end
            frame_no++;
        end
        no_idle = 1'b0;

        // let the last samples out, then watch for stray beats
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** vector_adpcm_frame_decoder: PASSED **");
        else
            $display("** vector_adpcm_frame_decoder: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/vadpcm_pkg.sv
hdl/vadpcm_cb_ram.sv
hdl/vadpcm_mac.sv
hdl/vadpcm_ctrl.sv
hdl/vector_adpcm_frame_decoder.sv
tb/testbench.sv
